// ===== hdl/plist_pkg.sv =====
// Shared types, widths and codes for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

  // List geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned ACT_W = 3;
  localparam int unsigned POS_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 9;

  // Width wide enough to compare counts and positions without overflow
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_PRIOR  = 3'd4,
    ACT_NEXT   = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_NOP    = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_READ,
    S_DEL_TAKE,
    S_DEL_SHIFT,
    S_GET_READ,
    S_GET_TAKE,
    S_SCAN,
    S_NEXT_TAKE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load_req;     // latch the request item
    logic    idx_load_cnt; // idx <= count
    logic    idx_load_pos; // idx <= position - 1
    logic    idx_clr;      // idx <= 0
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;        // issue a memory read
    logic    up;           // 1: read idx-1, write idx; 0: read idx, write idx-1
    logic    pend_set;     // write the read data back in the next cycle
    logic    scan_rd;      // the read feeds the search compare
    logic    put_val;      // write the request value at idx
    logic    take_rval;    // result value <= read data
    logic    take_prev;    // result value <= previous compared entry
    logic    take_fpos;    // found position <= compared index + 1
    logic    set_status;
    status_t status;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    out_load;     // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    act_t act;
    logic ins_pos_ok;
    logic full;
    logic rd_pos_ok;
    logic idx_ge_pos;
    logic idx_lt_cnt;
    logic hit;
    logic cmp_vld;
  } stat_t;

endpackage

// ===== hdl/plist_dp.sv =====
// Datapath: list memory, counters, request and result registers.
`timescale 1ns / 1ps

module plist_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  plist_pkg::cmd_t              cmd,
  output plist_pkg::stat_t             stat,
  input  logic [plist_pkg::ACT_W-1:0]  action,
  input  logic [plist_pkg::POS_W-1:0]  position,
  input  logic [plist_pkg::VAL_W-1:0]  value,
  output logic [1:0]                   status,
  output logic [plist_pkg::VAL_W-1:0]  result_value,
  output logic [plist_pkg::POS_W-1:0]  found_position,
  output logic [plist_pkg::LEN_W-1:0]  list_length
);

  localparam int unsigned ADDR_W = plist_pkg::ADDR_W;
  localparam int unsigned CNT_W  = plist_pkg::CNT_W;
  localparam int unsigned CMP_W  = plist_pkg::CMP_W;
  localparam int unsigned POS_W  = plist_pkg::POS_W;
  localparam int unsigned VAL_W  = plist_pkg::VAL_W;

  logic [VAL_W-1:0] mem [plist_pkg::CAPACITY];

  plist_pkg::act_t    req_act;
  logic [POS_W-1:0]   req_pos;
  logic [VAL_W-1:0]   req_val;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;
  logic [VAL_W-1:0]   rd_data;
  logic               cmp_vld;
  logic [CNT_W-1:0]   cmp_idx;
  logic [VAL_W-1:0]   prev_data;
  plist_pkg::status_t res_status;
  logic [VAL_W-1:0]   res_rval;
  logic [POS_W-1:0]   res_fpos;

  logic [CNT_W-1:0]   idx_m1;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wb_addr;
  logic               range_ok;

  // Address selection for shifts and scans
  always_comb begin
    idx_m1  = idx - CNT_W'(1);
    rd_addr = cmd.up ? ADDR_W'(idx_m1) : ADDR_W'(idx);
    wb_addr = cmd.up ? ADDR_W'(idx) : ADDR_W'(idx_m1);
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pend) begin
      mem[pend_addr] <= rd_data;
    end else if (cmd.put_val) begin
      mem[ADDR_W'(idx)] <= req_val;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request latch and write-back address
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_act <= plist_pkg::act_t'(action);
      req_pos <= position;
      req_val <= value;
    end
    if (cmd.pend_set) begin
      pend_addr <= wb_addr;
    end
    if (cmd.scan_rd) begin
      cmp_idx <= idx;
    end
    if (cmp_vld) begin
      prev_data <= rd_data;
    end
  end

  // Control registers: count, write-back flag, compare valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pend    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      pend    <= cmd.pend_set;
      cmp_vld <= cmd.scan_rd;
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.idx_load_cnt) begin
      idx <= count;
    end else if (cmd.idx_load_pos) begin
      idx <= CNT_W'(req_pos) - CNT_W'(1);
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
  end

  // Result under construction
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res_status <= plist_pkg::ST_OK;
      res_rval   <= '0;
      res_fpos   <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
      if (cmd.take_rval) begin
        res_rval <= rd_data;
      end else if (cmd.take_prev) begin
        res_rval <= prev_data;
      end
      if (cmd.take_fpos) begin
        res_fpos <= POS_W'(cmp_idx + CNT_W'(1));
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      result_value   <= res_rval;
      found_position <= res_fpos;
      list_length    <= plist_pkg::LEN_W'(count);
    end
  end

  // Search window: prior skips the first entry, next skips the last
  always_comb begin
    unique case (req_act)
      plist_pkg::ACT_PRIOR: range_ok = (cmp_idx != '0);
      plist_pkg::ACT_NEXT:  range_ok = (CMP_W'(cmp_idx) + CMP_W'(1)) < CMP_W'(count);
      default:              range_ok = 1'b1;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.act        = req_act;
    stat.ins_pos_ok = (req_pos != '0) &&
                      (CMP_W'(req_pos) <= (CMP_W'(count) + CMP_W'(1)));
    stat.full       = (count >= CNT_W'(plist_pkg::CAPACITY));
    stat.rd_pos_ok  = (req_pos != '0) && (CMP_W'(req_pos) <= CMP_W'(count));
    stat.idx_ge_pos = (CMP_W'(idx) >= CMP_W'(req_pos));
    stat.idx_lt_cnt = (idx < count);
    stat.hit        = cmp_vld && (rd_data == req_val) && range_ok;
    stat.cmp_vld    = cmp_vld;
  end

endmodule

// ===== hdl/plist_ctrl.sv =====
// Controller: state machine that sequences each request over the datapath.
`timescale 1ns / 1ps

module plist_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  plist_pkg::stat_t stat,
  output plist_pkg::cmd_t  cmd
);

  plist_pkg::state_t state;
  plist_pkg::state_t state_next;
  logic              rsp_valid_next;

  // State and response flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plist_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;

    unique case (state)
      plist_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = plist_pkg::S_DECIDE;
        end
      end

      // Check the position and pick the walk
      plist_pkg::S_DECIDE: begin
        state_next = plist_pkg::S_DONE;
        unique case (stat.act)
          plist_pkg::ACT_INSERT: begin
            if (!stat.ins_pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = plist_pkg::ST_BADPOS;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = plist_pkg::ST_FULL;
            end else begin
              cmd.idx_load_cnt = 1'b1;
              state_next       = plist_pkg::S_INS_SHIFT;
            end
          end
          plist_pkg::ACT_DELETE, plist_pkg::ACT_GET: begin
            if (!stat.rd_pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = plist_pkg::ST_BADPOS;
            end else begin
              cmd.idx_load_pos = 1'b1;
              state_next       = (stat.act == plist_pkg::ACT_DELETE) ?
                                 plist_pkg::S_DEL_READ : plist_pkg::S_GET_READ;
            end
          end
          plist_pkg::ACT_LOCATE, plist_pkg::ACT_PRIOR, plist_pkg::ACT_NEXT: begin
            cmd.idx_clr    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = plist_pkg::ST_NOTFOUND;
            state_next     = plist_pkg::S_SCAN;
          end
          plist_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // Move entries up from the tail down to the insert position
      plist_pkg::S_INS_SHIFT: begin
        if (stat.idx_ge_pos) begin
          cmd.rd_en    = 1'b1;
          cmd.up       = 1'b1;
          cmd.pend_set = 1'b1;
          cmd.idx_dec  = 1'b1;
        end else begin
          state_next = plist_pkg::S_INS_PUT;
        end
      end

      plist_pkg::S_INS_PUT: begin
        cmd.put_val = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = plist_pkg::S_DONE;
      end

      // Read the entry to be removed
      plist_pkg::S_DEL_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = plist_pkg::S_DEL_TAKE;
      end

      plist_pkg::S_DEL_TAKE: begin
        cmd.take_rval = 1'b1;
        state_next    = plist_pkg::S_DEL_SHIFT;
      end

      // Move later entries down by one
      plist_pkg::S_DEL_SHIFT: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en    = 1'b1;
          cmd.pend_set = 1'b1;
          cmd.idx_inc  = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = plist_pkg::S_DONE;
        end
      end

      plist_pkg::S_GET_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = plist_pkg::S_GET_TAKE;
      end

      plist_pkg::S_GET_TAKE: begin
        cmd.take_rval = 1'b1;
        state_next    = plist_pkg::S_DONE;
      end

      // Stream entries through the compare; stop at the first hit
      plist_pkg::S_SCAN: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.scan_rd = 1'b1;
          cmd.idx_inc = 1'b1;
        end
        if (stat.hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = plist_pkg::ST_OK;
          cmd.take_fpos  = (stat.act == plist_pkg::ACT_LOCATE);
          cmd.take_prev  = (stat.act == plist_pkg::ACT_PRIOR);
          state_next     = (stat.act == plist_pkg::ACT_NEXT) ?
                           plist_pkg::S_NEXT_TAKE : plist_pkg::S_DONE;
        end else if (!stat.idx_lt_cnt && !stat.cmp_vld) begin
          state_next = plist_pkg::S_DONE;
        end
      end

      // The entry after the hit was read during the hit cycle
      plist_pkg::S_NEXT_TAKE: begin
        cmd.take_rval = 1'b1;
        state_next    = plist_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free
      plist_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = plist_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = plist_pkg::S_IDLE;
      end
    endcase

    priority if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: controller plus datapath.
`timescale 1ns / 1ps
// Ordered list of up to 256 signed 32-bit entries with a length.
// Request channel (req_valid/req_ready) carries action, position, value;
// response channel (rsp_valid/rsp_ready) returns status, result_value,
// found_position and list_length, one response item per request item.
// One request is worked on at a time; a new request is taken while the
// previous response still waits in the output register.
// Insert shifts entries from the tail down to the position, delete shifts
// entries from the position to the tail, get reads one entry; searches
// stream entries from the head until a hit or the end of the list, and
// next also reads the entry after the hit. Clear, unused codes and
// rejected requests go straight to the response.
// With no stall the next request can be taken in the cycle after the
// response is loaded.
// Insert, delete and searches walk the single list memory: one read
// and one write per cycle, with registered read data.
// Reset empties the list and drops any pending response; the memory is not
// cleared, since no entry at or above the length is ever read.
// When the receiver stalls, the finished response is held and the engine
// waits before loading the next one, so no item is lost or repeated.

module positional_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic        [plist_pkg::ACT_W-1:0] action,
  input  logic        [plist_pkg::POS_W-1:0] position,
  input  logic signed [plist_pkg::VAL_W-1:0] value,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic        [1:0]                  status,
  output logic signed [plist_pkg::VAL_W-1:0] result_value,
  output logic        [plist_pkg::POS_W-1:0] found_position,
  output logic        [plist_pkg::LEN_W-1:0] list_length
);

  plist_pkg::cmd_t  cmd;
  plist_pkg::stat_t stat;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plist_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .position       (position),
    .value          (value),
    .status         (status),
    .result_value   (result_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

endmodule
